>>> rtl/core/assert_macros.svh
// assertion macros for the rtl core, used by mb64_back
// no dependencies; expects i_clk and i_rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mb64_pkg.sv
// types, constants and lookup functions of the masked base64 name codec
// no dependencies
package mb64_pkg;

    localparam int POS_W = 4;
    localparam int ACC_W = 24;
    localparam int KEY_LEN = 10;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [7:0] KEY [KEY_LEN] = '{
        8'h54, 8'h61, 8'h6f, 8'h62, 8'h61, 8'h6f, 8'h2d, 8'h69, 8'h6e, 8'h63
    };

    // first symbol in the top byte
    localparam logic [511:0] ALPHABET = {
        "0JoU8EaN3xf19hIS2d.6pZRFBYurMDGw",
        "7K5m4CyXsbQjg_vTOAkcHVtzqWilnLPe"
    };

    // one queued job: up to four result bytes of one item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            done;
    } t_job;

    // index below twice the key length
    function automatic logic [7:0] key_at(input logic [4:0] idx);
        logic [4:0] k;
        k = (idx >= 5'd10) ? idx - 5'd10 : idx;
        return KEY[k[3:0]];
    endfunction

    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        return ALPHABET[{~s, 3'b000} +: 8];
    endfunction

    // symbols are distinct, so an or of the matches gives the index
    function automatic logic [5:0] sym_value(input logic [7:0] c);
        logic [5:0] v;
        v = '0;
        for (int j = 0; j < 64; j++) begin
            if (ALPHABET[8*(63-j) +: 8] == c) begin
                v = v | 6'(j);
            end
        end
        return v;
    endfunction

endpackage

>>> rtl/core/mb64_fifo.sv
// two-entry job queue between the front and back parts
// depends on mb64_pkg
module mb64_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mb64_pkg::t_job    i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output mb64_pkg::t_job    o_head
);
    import mb64_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

>>> rtl/core/mb64_front.sv
// front part: accepts beats, keeps name position and partial group, builds jobs
// depends on mb64_pkg
module mb64_front #(
    parameter int NAME_BYTES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [7:0]        i_data,
    input  logic              i_start_req,
    input  logic              i_full,
    output logic              o_push,
    output mb64_pkg::t_job    o_job
);
    import mb64_pkg::*;

    localparam logic [POS_W-1:0] NB = POS_W'(NAME_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_gc, n_gc;
    logic [ACC_W-1:0] r_acc, n_acc;

    logic [POS_W-1:0] eff_pos, pos_e, pos_d, remain;
    logic [1:0]       eff_gc, n_d;
    logic [ACC_W-1:0] eff_acc, acc_e, acc_d, v_e;
    logic [2:0]       cnt_e;
    logic [7:0]       b_e;
    logic             done_e, done_d, emit_e, emit_d, emit, accept;
    t_job             job;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    always_comb begin
        eff_pos = i_start_req ? '0 : r_pos;
        eff_gc  = i_start_req ? '0 : r_gc;
        eff_acc = i_start_req ? '0 : r_acc;

        // encode side
        b_e    = i_data ^ key_at({1'b0, eff_pos});
        cnt_e  = {1'b0, eff_gc} + 3'd1;
        acc_e  = {eff_acc[15:0], b_e};
        pos_e  = eff_pos + 4'd1;
        done_e = (pos_e >= NB);
        emit_e = (cnt_e >= 3'd3) || done_e;
        case (cnt_e)
            3'd1: v_e = {acc_e[7:0], 16'h0000};
            3'd2: v_e = {acc_e[15:0], 8'h00};
            default: v_e = acc_e;
        endcase

        // decode side
        acc_d  = {eff_acc[17:0], sym_value(i_data)};
        emit_d = (eff_gc == 2'd3);
        remain = (eff_pos < NB) ? NB - eff_pos : 4'd1;
        n_d    = (remain < 4'd3) ? remain[1:0] : 2'd3;
        pos_d  = eff_pos + {2'b00, n_d};
        done_d = (pos_d >= NB);

        job = '0;
        if (i_func == FUNC_ENCODE) begin
            for (int k = 0; k < 4; k++) begin
                job.bytes[k] = alpha_char(v_e[ACC_W-1-6*k -: 6]);
            end
            job.cnt  = 3'd4;
            job.done = done_e;
            emit     = emit_e;
        end else begin
            for (int k = 0; k < 3; k++) begin
                job.bytes[k] = acc_d[ACC_W-1-8*k -: 8] ^ key_at({1'b0, eff_pos} + 5'(k));
            end
            job.cnt  = {1'b0, n_d};
            job.done = done_d;
            emit     = emit_d;
        end

        n_pos = r_pos;
        n_gc  = r_gc;
        n_acc = r_acc;
        if (accept) begin
            if (emit) begin
                n_gc  = '0;
                n_acc = '0;
                if (job.done) begin
                    n_pos = '0;
                end else begin
                    n_pos = (i_func == FUNC_ENCODE) ? pos_e : pos_d;
                end
            end else if (i_func == FUNC_ENCODE) begin
                n_gc  = cnt_e[1:0];
                n_acc = acc_e;
                n_pos = pos_e;
            end else begin
                n_gc  = eff_gc + 2'd1;
                n_acc = acc_d;
                n_pos = eff_pos;
            end
        end
    end

    assign o_push = accept && emit;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_gc  <= '0;
            r_acc <= '0;
        end else begin
            r_pos <= n_pos;
            r_gc  <= n_gc;
            r_acc <= n_acc;
        end
    end

endmodule

>>> rtl/core/mb64_back.sv
// back part: walks the bytes of the head job into the output register
// depends on mb64_pkg and assert_macros.svh
`include "assert_macros.svh"

module mb64_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mb64_pkg::t_job    i_q_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_value,
    output logic              o_last,
    output logic              o_name_done
);
    import mb64_pkg::*;

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_value;
    logic       r_last, r_done;
    logic       load, is_last;

    assign load    = i_q_valid && (!r_valid || !i_stall);
    assign is_last = ({1'b0, r_idx} == (i_q_head.cnt - 3'd1));
    assign o_pop   = load && is_last;

    always_comb begin
        n_idx = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (load) begin
            n_idx = r_idx + 2'd1;
        end
        if (load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_q_head.bytes[r_idx];
            r_last  <= is_last;
            r_done  <= is_last && i_q_head.done;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_value = r_value;
    assign o_last      = r_last;
    assign o_name_done = r_done;

    `CHK_NOW(a_done_on_last, r_valid && r_done, r_last, "name end on a beat that is not last")
    `CHK_NOW(a_idx_in_job, i_q_valid, ({1'b0, r_idx} < i_q_head.cnt), "byte index past job")
    `CHK_NEXT(a_idx_clear, o_pop, r_idx == 2'd0, "byte index not cleared after pop")
    `CHK_NEXT(a_load_shows, load, r_valid, "loaded beat not presented")

endmodule

>>> rtl/core/masked_base64_name_codec_top.sv
// masked base64 name codec: top level joining front, job queue and back
// depends on mb64_pkg, mb64_front, mb64_fifo, mb64_back
//
// input channel: i_valid / o_stall with i_func, i_data, i_start_req, one beat
//   per record byte (encode) or name character (decode)
// output channel: o_valid / i_stall with o_out_value, o_last, o_name_done
// an encode beat gives no result or four characters; a decode beat gives none
//   or one to three record bytes; o_last marks the final result of a beat and
//   o_name_done the final result of the whole name
// the first result of a beat passes through the job queue and then the output
//   register before it is presented
// throughput: one input beat per cycle while the output keeps up; the output
//   register gives one result per cycle while i_stall is low, so encoding, at
//   four characters to three beats, lags; decoding keeps one beat per cycle
// a two-entry job queue parts the two sides: a stalled receiver holds the
//   output register and the queue fills, after which o_stall rises
// reset (synchronous, active low) clears position, partial group, queue and
//   output valid; no result is lost or repeated across stalls
module masked_base64_name_codec_top #(
    parameter int NAME_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_func,
    input  logic [7:0] i_data,
    input  logic       i_start_req,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_value,
    output logic       o_last,
    output logic       o_name_done
);
    import mb64_pkg::*;

    logic full, push, pop, q_valid;
    t_job job, head;

    mb64_front #(
        .NAME_BYTES(NAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_data      (i_data),
        .i_start_req (i_start_req),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job)
    );

    mb64_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    mb64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_value (o_out_value),
        .o_last      (o_last),
        .o_name_done (o_name_done)
    );

endmodule
